// File: src/dec_pkg.sv
// Shared types and constants for the two-disk elastic collision pipeline.
`default_nettype none

package dec_pkg;

  // Quotient bits produced per velocity change; the change is clamped to 2^34.
  localparam int unsigned QW = 35;
  // Divisor width: 2 * dist2 * (m1 + m2).
  localparam int unsigned DW = 83;
  // Dividend width: 2 * num + den.
  localparam int unsigned NW = 116;

  // Largest velocity change applied, in Q16.16 raw units.
  localparam logic [QW-1:0] Q_CLAMP = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [1:0] {
    OUTC_NONE     = 2'd0,
    OUTC_RESOLVED = 2'd1,
    OUTC_DEGEN    = 2'd2
  } outcome_t;

  // One velocity component on its way through the divider.
  typedef struct packed {
    logic          neg;   // change is subtracted
    logic          ovf;   // quotient >= 2^QW
    logic [DW-1:0] rem;   // partial remainder
    logic [QW-1:0] nlo;   // dividend bits still to shift in
    logic [QW-1:0] quo;   // quotient bits so far
    logic [31:0]   vel;   // velocity before the collision
  } lane_t;

  // Lanes: 0 first x, 1 first y, 2 second x, 3 second y.
  typedef struct packed {
    outcome_t        outc;
    logic [DW-1:0]   dvs;
    lane_t [3:0]     lane;
  } div_t;

endpackage

`default_nettype wire

// File: src/dec_if.sv
// Valid/ready channel interfaces for disk pair requests and collision results.
`default_nettype none

interface dec_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_pos_x;
  logic signed [31:0] first_pos_y;
  logic signed [31:0] second_pos_x;
  logic signed [31:0] second_pos_y;
  logic signed [31:0] first_vel_x;
  logic signed [31:0] first_vel_y;
  logic signed [31:0] second_vel_x;
  logic signed [31:0] second_vel_y;
  logic [30:0]        first_radius;
  logic [30:0]        second_radius;
  logic [15:0]        first_mass;
  logic [15:0]        second_mass;

  modport source (
    output valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
           first_vel_x, first_vel_y, second_vel_x, second_vel_y,
           first_radius, second_radius, first_mass, second_mass,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
           first_vel_x, first_vel_y, second_vel_x, second_vel_y,
           first_radius, second_radius, first_mass, second_mass,
    output ready
  );
endinterface

interface dec_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_new_vel_x;
  logic signed [31:0] first_new_vel_y;
  logic signed [31:0] second_new_vel_x;
  logic signed [31:0] second_new_vel_y;
  logic [1:0]         outcome;
  logic               saturated;

  modport source (
    output valid, first_new_vel_x, first_new_vel_y, second_new_vel_x,
           second_new_vel_y, outcome, saturated,
    input  ready
  );
  modport sink (
    input  valid, first_new_vel_x, first_new_vel_y, second_new_vel_x,
           second_new_vel_y, outcome, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: src/dec_front.sv
// Front pipeline: differences, products, collision test and divider setup.
`default_nettype none

module dec_front (
  input  logic          clk,
  input  logic          rst_n,
  dec_in_if.sink        in_ch,
  output dec_pkg::div_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);

  localparam int unsigned NS  = 8;   // register stages in this module
  localparam int unsigned TW  = 82;  // dotm * 2m and dist2 * msum
  localparam int unsigned PW  = 60;  // partial product
  localparam int unsigned MW  = 114; // full numerator

  typedef struct packed {
    logic [32:0]      dx, dy, dvx, dvy;
    logic [31:0]      rsum;
    logic [16:0]      msum;
    logic [15:0]      m1, m2;
    logic [3:0][31:0] vel;
  } s1_t;

  typedef struct packed {
    logic [63:0]      sqx, sqy, rs2, pa, pb;
    logic             sdx, sdy, sdvx, sdvy;
    logic [31:0]      dxm, dym;
    logic [16:0]      msum;
    logic [15:0]      m1, m2;
    logic [3:0][31:0] vel;
  } s2_t;

  typedef struct packed {
    logic [64:0]       dist2, dotm;
    dec_pkg::outcome_t outc;
    logic [3:0]        neg;
    logic [31:0]       dxm, dym;
    logic [16:0]       msum;
    logic [15:0]       m1, m2;
    logic [3:0][31:0]  vel;
  } s3_t;

  typedef struct packed {
    logic [TW-1:0]     den, ta, tb;
    logic [31:0]       dxm, dym;
    logic [3:0]        neg;
    logic [3:0][31:0]  vel;
    dec_pkg::outcome_t outc;
  } s4_t;

  typedef struct packed {
    logic [3:0][2:0][PW-1:0] pp;
    logic [TW-1:0]           den;
    logic [3:0]              neg;
    logic [3:0][31:0]        vel;
    dec_pkg::outcome_t       outc;
  } s5_t;

  typedef struct packed {
    logic [3:0][MW-1:0] num;
    logic [TW-1:0]      den;
    logic [3:0]         neg;
    logic [3:0][31:0]   vel;
    dec_pkg::outcome_t  outc;
  } s6_t;

  typedef struct packed {
    logic [3:0][dec_pkg::NW-1:0] nd;
    logic [dec_pkg::DW-1:0]      dvs;
    logic [3:0]                  neg;
    logic [3:0][31:0]            vel;
    dec_pkg::outcome_t           outc;
  } s7_t;

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = v[32] ? (~v + 33'd1) : v;
    return n[31:0];
  endfunction

  logic [NS:1]   vld_r, vld_nxt;
  logic [NS+1:1] rdy;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;
  s7_t s7_r, s7_nxt;
  dec_pkg::div_t s8_r, s8_nxt;

  // Per-stage ready: a stage takes new data when empty or when it drains.
  always_comb begin
    rdy[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    if (rdy[1]) vld_nxt[1] = in_ch.valid;
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: differences and sums
  always_comb begin
    s1_nxt.dx   = {in_ch.second_pos_x[31], in_ch.second_pos_x}
                - {in_ch.first_pos_x[31], in_ch.first_pos_x};
    s1_nxt.dy   = {in_ch.second_pos_y[31], in_ch.second_pos_y}
                - {in_ch.first_pos_y[31], in_ch.first_pos_y};
    s1_nxt.dvx  = {in_ch.first_vel_x[31], in_ch.first_vel_x}
                - {in_ch.second_vel_x[31], in_ch.second_vel_x};
    s1_nxt.dvy  = {in_ch.first_vel_y[31], in_ch.first_vel_y}
                - {in_ch.second_vel_y[31], in_ch.second_vel_y};
    s1_nxt.rsum = {1'b0, in_ch.first_radius} + {1'b0, in_ch.second_radius};
    s1_nxt.msum = {1'b0, in_ch.first_mass} + {1'b0, in_ch.second_mass};
    s1_nxt.m1   = in_ch.first_mass;
    s1_nxt.m2   = in_ch.second_mass;
    s1_nxt.vel[0] = in_ch.first_vel_x;
    s1_nxt.vel[1] = in_ch.first_vel_y;
    s1_nxt.vel[2] = in_ch.second_vel_x;
    s1_nxt.vel[3] = in_ch.second_vel_y;
  end

  // Stage 2: squares and dot-product terms on magnitudes
  always_comb begin
    logic [31:0] dvxm, dvym;
    dvxm = mag33(s1_r.dvx);
    dvym = mag33(s1_r.dvy);
    s2_nxt.dxm  = mag33(s1_r.dx);
    s2_nxt.dym  = mag33(s1_r.dy);
    s2_nxt.sqx  = 64'(s2_nxt.dxm) * 64'(s2_nxt.dxm);
    s2_nxt.sqy  = 64'(s2_nxt.dym) * 64'(s2_nxt.dym);
    s2_nxt.rs2  = 64'(s1_r.rsum) * 64'(s1_r.rsum);
    s2_nxt.pa   = 64'(s2_nxt.dxm) * 64'(dvxm);
    s2_nxt.pb   = 64'(s2_nxt.dym) * 64'(dvym);
    s2_nxt.sdx  = s1_r.dx[32];
    s2_nxt.sdy  = s1_r.dy[32];
    s2_nxt.sdvx = s1_r.dvx[32];
    s2_nxt.sdvy = s1_r.dvy[32];
    s2_nxt.msum = s1_r.msum;
    s2_nxt.m1   = s1_r.m1;
    s2_nxt.m2   = s1_r.m2;
    s2_nxt.vel  = s1_r.vel;
  end

  // Stage 3: distance, signed dot product, collision class, lane signs
  always_comb begin
    logic na, nb, dneg;
    na = s2_r.sdx ^ s2_r.sdvx;
    nb = s2_r.sdy ^ s2_r.sdvy;
    s3_nxt.dist2 = {1'b0, s2_r.sqx} + {1'b0, s2_r.sqy};
    if (na == nb) begin
      s3_nxt.dotm = {1'b0, s2_r.pa} + {1'b0, s2_r.pb};
      dneg = na;
    end else if (s2_r.pa >= s2_r.pb) begin
      s3_nxt.dotm = {1'b0, s2_r.pa - s2_r.pb};
      dneg = na;
    end else begin
      s3_nxt.dotm = {1'b0, s2_r.pb - s2_r.pa};
      dneg = nb;
    end
    if (s3_nxt.dotm == '0) dneg = 1'b0;
    // first disk loses the change, second disk gains it
    s3_nxt.neg[0] = (dneg == s2_r.sdx);
    s3_nxt.neg[1] = (dneg == s2_r.sdy);
    s3_nxt.neg[2] = dneg ^ s2_r.sdx;
    s3_nxt.neg[3] = dneg ^ s2_r.sdy;
    if ({1'b0, s2_r.rs2} <= s3_nxt.dist2) begin
      s3_nxt.outc = dec_pkg::OUTC_NONE;
    end else if (s3_nxt.dist2 == '0 || s2_r.msum == '0) begin
      s3_nxt.outc = dec_pkg::OUTC_DEGEN;
    end else begin
      s3_nxt.outc = dec_pkg::OUTC_RESOLVED;
    end
    s3_nxt.dxm  = s2_r.dxm;
    s3_nxt.dym  = s2_r.dym;
    s3_nxt.msum = s2_r.msum;
    s3_nxt.m1   = s2_r.m1;
    s3_nxt.m2   = s2_r.m2;
    s3_nxt.vel  = s2_r.vel;
  end

  // Stage 4: denominator and mass-scaled dot products
  always_comb begin
    s4_nxt.den  = TW'(s3_r.dist2) * TW'(s3_r.msum);
    s4_nxt.ta   = TW'(s3_r.dotm) * TW'({s3_r.m2, 1'b0});
    s4_nxt.tb   = TW'(s3_r.dotm) * TW'({s3_r.m1, 1'b0});
    s4_nxt.dxm  = s3_r.dxm;
    s4_nxt.dym  = s3_r.dym;
    s4_nxt.neg  = s3_r.neg;
    s4_nxt.vel  = s3_r.vel;
    s4_nxt.outc = s3_r.outc;
  end

  // Stage 5: partial products of t * |d| per lane
  always_comb begin
    logic [TW-1:0] t;
    logic [31:0]   d;
    for (int l = 0; l < 4; l++) begin
      t = (l < 2) ? s4_r.ta : s4_r.tb;
      d = (l % 2 == 0) ? s4_r.dxm : s4_r.dym;
      s5_nxt.pp[l][0] = PW'(t[27:0]) * PW'(d);
      s5_nxt.pp[l][1] = PW'(t[55:28]) * PW'(d);
      s5_nxt.pp[l][2] = PW'(t[81:56]) * PW'(d);
    end
    s5_nxt.den  = s4_r.den;
    s5_nxt.neg  = s4_r.neg;
    s5_nxt.vel  = s4_r.vel;
    s5_nxt.outc = s4_r.outc;
  end

  // Stage 6: sum partial products
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      s6_nxt.num[l] = MW'(s5_r.pp[l][0]) + (MW'(s5_r.pp[l][1]) << 28)
                    + (MW'(s5_r.pp[l][2]) << 56);
    end
    s6_nxt.den  = s5_r.den;
    s6_nxt.neg  = s5_r.neg;
    s6_nxt.vel  = s5_r.vel;
    s6_nxt.outc = s5_r.outc;
  end

  // Stage 7: rounded dividend 2*num + den, divisor 2*den
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      s7_nxt.nd[l] = dec_pkg::NW'({s6_r.num[l], 1'b0}) + dec_pkg::NW'(s6_r.den);
    end
    s7_nxt.dvs  = {s6_r.den, 1'b0};
    s7_nxt.neg  = s6_r.neg;
    s7_nxt.vel  = s6_r.vel;
    s7_nxt.outc = s6_r.outc;
  end

  // Stage 8: overflow check and initial partial remainder
  always_comb begin
    s8_nxt.outc = s7_r.outc;
    s8_nxt.dvs  = s7_r.dvs;
    for (int l = 0; l < 4; l++) begin
      s8_nxt.lane[l].neg = s7_r.neg[l];
      s8_nxt.lane[l].vel = s7_r.vel[l];
      s8_nxt.lane[l].ovf = dec_pkg::DW'(s7_r.nd[l][dec_pkg::NW-1:dec_pkg::QW]) >= s7_r.dvs;
      s8_nxt.lane[l].rem = dec_pkg::DW'(s7_r.nd[l][dec_pkg::NW-1:dec_pkg::QW]);
      s8_nxt.lane[l].nlo = s7_r.nd[l][dec_pkg::QW-1:0];
      s8_nxt.lane[l].quo = '0;
    end
  end

  // Payload registers, loaded whenever the stage may advance
  always_ff @(posedge clk) begin
    if (rdy[1]) s1_r <= s1_nxt;
    if (rdy[2]) s2_r <= s2_nxt;
    if (rdy[3]) s3_r <= s3_nxt;
    if (rdy[4]) s4_r <= s4_nxt;
    if (rdy[5]) s5_r <= s5_nxt;
    if (rdy[6]) s6_r <= s6_nxt;
    if (rdy[7]) s7_r <= s7_nxt;
    if (rdy[8]) s8_r <= s8_nxt;
  end

  assign in_ch.ready = rdy[1];
  assign out_valid   = vld_r[NS];
  assign out_data    = s8_r;

  // An accepted request always occupies the first stage next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[1])
    else $error("accepted request did not enter stage 1");

endmodule

`default_nettype wire

// File: src/dec_div_stage.sv
// One restoring division step (one quotient bit) for all four lanes.
`default_nettype none

module dec_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dec_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dec_pkg::div_t out_data
);

  dec_pkg::div_t step_r, step_nxt;
  logic          vld_r;
  logic          rem_ok;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    logic [dec_pkg::DW:0] shv, diff;
    logic                 ge;
    step_nxt = in_data;
    for (int l = 0; l < 4; l++) begin
      shv  = {in_data.lane[l].rem, in_data.lane[l].nlo[dec_pkg::QW-1]};
      diff = shv - {1'b0, in_data.dvs};
      ge   = shv >= {1'b0, in_data.dvs};
      step_nxt.lane[l].rem = ge ? diff[dec_pkg::DW-1:0] : shv[dec_pkg::DW-1:0];
      step_nxt.lane[l].nlo = {in_data.lane[l].nlo[dec_pkg::QW-2:0], 1'b0};
      step_nxt.lane[l].quo = {in_data.lane[l].quo[dec_pkg::QW-2:0], ge};
    end
  end

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) step_r <= step_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = step_r;

  // Remainder stays below the divisor on every lane that did not overflow
  always_comb begin
    rem_ok = 1'b1;
    for (int l = 0; l < 4; l++) begin
      if (!step_r.lane[l].ovf && step_r.lane[l].rem >= step_r.dvs) rem_ok = 1'b0;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && step_r.outc == dec_pkg::OUTC_RESOLVED |-> rem_ok)
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// File: src/dec_back.sv
// Output stage: clamp the change, apply it, saturate, select by outcome.
`default_nettype none

module dec_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dec_pkg::div_t in_data,
  dec_out_if.source     out_ch
);

  typedef struct packed {
    logic [3:0][31:0]  vel;
    dec_pkg::outcome_t outc;
    logic              sat;
  } res_t;

  res_t res_r, res_nxt;
  logic vld_r;

  always_comb begin
    logic [dec_pkg::QW-1:0] dq;
    logic [36:0]            vx, dqx, sum;
    logic [3:0][31:0]       newv;
    logic                   sat;
    sat  = 1'b0;
    newv = '0;
    for (int l = 0; l < 4; l++) begin
      // clamp the rounded change
      if (in_data.lane[l].ovf || in_data.lane[l].quo > dec_pkg::Q_CLAMP) begin
        dq = dec_pkg::Q_CLAMP;
      end else begin
        dq = in_data.lane[l].quo;
      end
      vx  = {{5{in_data.lane[l].vel[31]}}, in_data.lane[l].vel};
      dqx = {2'b00, dq};
      sum = in_data.lane[l].neg ? (vx - dqx) : (vx + dqx);
      // fits when the top six bits agree
      if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
        newv[l] = sum[31:0];
      end else begin
        sat     = 1'b1;
        newv[l] = sum[36] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end

    res_nxt.outc = in_data.outc;
    case (in_data.outc)
      dec_pkg::OUTC_RESOLVED: begin
        res_nxt.vel = newv;
        res_nxt.sat = sat;
      end
      dec_pkg::OUTC_DEGEN: begin
        for (int l = 0; l < 4; l++) res_nxt.vel[l] = in_data.lane[l].vel;
        res_nxt.sat = 1'b0;
      end
      dec_pkg::OUTC_NONE: begin
        res_nxt.vel = '0;
        res_nxt.sat = 1'b0;
      end
      default: begin
        res_nxt.vel = '0;
        res_nxt.sat = 1'b0;
      end
    endcase
  end

  assign in_ready = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) res_r <= res_nxt;
  end

  assign out_ch.valid            = vld_r;
  assign out_ch.first_new_vel_x  = res_r.vel[0];
  assign out_ch.first_new_vel_y  = res_r.vel[1];
  assign out_ch.second_new_vel_x = res_r.vel[2];
  assign out_ch.second_new_vel_y = res_r.vel[3];
  assign out_ch.outcome          = res_r.outc;
  assign out_ch.saturated        = res_r.sat;

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && res_r.outc == dec_pkg::OUTC_NONE |-> res_r.vel == '0 && !res_r.sat)
    else $error("non-colliding pair produced nonzero result");

  a_sat_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && res_r.sat |-> res_r.outc == dec_pkg::OUTC_RESOLVED)
    else $error("saturation flagged outside a resolved collision");

endmodule

`default_nettype wire

// File: src/disk_elastic_collision_2d.sv
// Top level of the two-disk elastic collision pipeline.
//
//   channel  | direction | contents
//   ---------+-----------+---------------------------------------------------
//   in_ch    | sink      | two disks: positions, velocities, radii, masses
//   out_ch   | source    | four exit velocities, outcome, saturated flag
//
// One request per clock while out_ch is ready; the path is 8 front stages,
// 35 divider stages at one quotient bit each, and 1 output register.
// The divider chain length follows the quotient width (35 bits).
// Synchronous active-low reset clears all valid bits; data registers keep state.
// Every stage has its own ready, so a stall at out_ch fills bubbles first and
// then holds each request in place, none dropped or repeated.
`default_nettype none

module disk_elastic_collision_2d (
  input  logic      clk,
  input  logic      rst_n,
  dec_in_if.sink    in_ch,
  dec_out_if.source out_ch
);

  localparam int unsigned NSTG = dec_pkg::QW;

  dec_pkg::div_t  stg_data [0:NSTG];
  logic [NSTG:0]  stg_valid;
  logic [NSTG:0]  stg_ready;

  dec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_data  (stg_data[0]),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar g = 0; g < NSTG; g++) begin : g_div
    dec_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  dec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stg_valid[NSTG]),
    .in_ready (stg_ready[NSTG]),
    .in_data  (stg_data[NSTG]),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
